### design/tli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the table interpolator: the word formats,
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

  // input word codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // divider geometry: 65-bit rounded numerator, 32-bit divisor
  localparam int MAG_W     = 32;
  localparam int NUM_W     = 65;
  localparam int DIV_STEPS = 65;
  localparam int DCNT_W    = 7;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] value;
    logic signed [31:0] query_x;
    logic [1:0]         abscissa_col;
    logic [1:0]         ordinate_col;
  } tli_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               order_error;
    logic               div_zero;
  } tli_out_t;

  // which segment corner a fetch reads
  typedef enum logic [1:0] {
    FETCH_X0,
    FETCH_X1,
    FETCH_Y0,
    FETCH_Y1
  } tli_fetch_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       write;
    logic       rd_en;
    logic       rd_fetch;
    tli_fetch_t rd_sel;
    logic       scan_proc;
    logic       scan_first;
    logic       scan_last;
    logic       scan_inner;
    logic       fetch_cap;
    tli_fetch_t cap_sel;
    logic       seg_calc;
    logic       diff;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       sum;
    logic       load_done;
    logic       dz_done;
  } tli_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dx_zero;
  } tli_sts_t;

endpackage
`default_nettype wire

### design/table_linear_interpolator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// Piecewise linear interpolation over a loaded table of Q16.16 words, with
// end-segment extrapolation, order check and saturated result.
// ----------------------------------------------------------------------------
// load word: written to the table in S_LOAD, then an all-zero result word from S_DONE
// query word: row scan over one read port at one row a cycle, segment fetch,
//   then the 65-step divider, which a zero-width segment skips
// one word in flight at a time; the output register frees the input side
// reset: synchronous, clears control and sets num_rows to 2; table unset
module table_linear_interpolator_core #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  tli_pkg::tli_in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tli_pkg::tli_out_t out_data,
  input  wire logic         cfg_wr_en,
  input  wire logic [8:0]   cfg_wr_data
);
  import tli_pkg::*;

  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  logic [NW-1:0] num_rows_r, num_rows_nxt;
  tli_cmd_t      cmd;
  tli_sts_t      sts;
  tli_out_t      res;
  logic [RB-1:0] scan_row, proc_row;
  logic          res_valid, res_take;
  logic          out_valid_r;
  tli_out_t      out_data_r;

  // row count register, clamped into range on write
  always_comb begin
    num_rows_nxt = num_rows_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < 9'd2) begin
        num_rows_nxt = NW'(2);
      end else if (32'(cfg_wr_data) > MAX_ROWS) begin
        num_rows_nxt = NW'(MAX_ROWS);
      end else begin
        num_rows_nxt = NW'(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NW'(2);
    end else begin
      num_rows_r <= num_rows_nxt;
    end
  end

  tli_ctrl #(.NW(NW), .RB(RB)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .num_rows  (num_rows_r),
    .sts       (sts),
    .cmd       (cmd),
    .scan_row  (scan_row),
    .proc_row  (proc_row),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  tli_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .NW       (NW),
    .RB       (RB),
    .AW       (AW)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_word  (in_data),
    .num_rows (num_rows_r),
    .scan_row (scan_row),
    .proc_row (proc_row),
    .sts      (sts),
    .res      (res)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || out_ready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid)
    else $error("result word not presented after handoff");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_zero) |-> (out_data.result == '0))
    else $error("zero-width segment with nonzero result");

  a_rows_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (num_rows_r >= NW'(2)))
    else $error("row count below two");

endmodule
`default_nettype wire

### design/tli_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for loads and queries: row scan, segment fetch, multiply and
// the bit-serial divide, then hands the result word to the output stage.
// ----------------------------------------------------------------------------
module tli_ctrl #(
  parameter int NW = 9,
  parameter int RB = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  output logic                 in_ready,
  input  wire logic [NW-1:0]   num_rows,
  input  tli_pkg::tli_sts_t    sts,
  output tli_pkg::tli_cmd_t    cmd,
  output logic [RB-1:0]        scan_row,
  output logic [RB-1:0]        proc_row,
  output logic                 res_valid,
  input  wire logic            res_take
);
  import tli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN, S_SEG, S_FETCH, S_DIFF, S_MUL, S_INIT, S_DIV,
    S_SUM, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [2:0]        fcnt_r, fcnt_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [NW-1:0]     cnt_m1;
  logic [2:0]        fcnt_m1;

  assign cnt_m1   = cnt_r - NW'(1);
  assign fcnt_m1  = fcnt_r - 3'd1;
  assign scan_row = cnt_r[RB-1:0];
  assign proc_row = cnt_m1[RB-1:0];
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fcnt_nxt  = fcnt_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = (in_cmd == CMD_QUERY) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.write     = 1'b1;
        cmd.load_done = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SCAN: begin
        cmd.rd_en      = (cnt_r < num_rows);
        cmd.scan_proc  = (cnt_r != '0);
        cmd.scan_first = (cnt_r == NW'(1));
        cmd.scan_last  = (cnt_r == num_rows);
        cmd.scan_inner = (cnt_r < num_rows);
        cnt_nxt        = cnt_r + NW'(1);
        if (cnt_r == num_rows) begin
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        cmd.seg_calc = 1'b1;
        fcnt_nxt     = '0;
        state_nxt    = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_en     = (fcnt_r != 3'd4);
        cmd.rd_fetch  = 1'b1;
        cmd.rd_sel    = tli_fetch_t'(fcnt_r[1:0]);
        cmd.fetch_cap = (fcnt_r != 3'd0);
        cmd.cap_sel   = tli_fetch_t'(fcnt_m1[1:0]);
        fcnt_nxt      = fcnt_r + 3'd1;
        if (fcnt_r == 3'd4) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.dx_zero) begin
          cmd.dz_done = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fcnt_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fcnt_r  <= fcnt_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule
`default_nettype wire

### design/tli_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tli_dp
// Datapath: table memory, scan registers for order check and segment
// search, corner registers, multiplier and restoring divider, saturation.
// ----------------------------------------------------------------------------
module tli_dp #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 4,
  parameter int NW       = 9,
  parameter int RB       = 8,
  parameter int AW       = 10
) (
  input  wire logic          clk,
  input  tli_pkg::tli_cmd_t  cmd,
  input  tli_pkg::tli_in_t   in_word,
  input  wire logic [NW-1:0] num_rows,
  input  wire logic [RB-1:0] scan_row,
  input  wire logic [RB-1:0] proc_row,
  output tli_pkg::tli_sts_t  sts,
  output tli_pkg::tli_out_t  res
);
  import tli_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
  localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

  logic [31:0]        mem [DEPTH];
  tli_in_t            item_r;
  logic [31:0]        rd_data_r;
  logic               rd_ok_r;
  logic signed [31:0] rd_word;

  logic signed [31:0] prev_r, last_r;
  logic               order_r, found_r;
  logic [RB-1:0]      k_r, seg_r;
  logic signed [31:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [32:0] dx_r, dy_r, t_r;
  logic               neg_r;
  logic [MAG_W-1:0]   d_r;
  logic [2*MAG_W-1:0] p_r;
  logic [NUM_W-1:0]   num_r;
  logic [MAG_W-1:0]   rem_r;
  tli_out_t           res_r;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
  end

  // table write
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  assign wr_ok   = (32'(item_r.row_index) < MAX_ROWS) && (32'(item_r.col_index) < MAX_COLS);
  assign wr_addr = AW'(item_r.row_index) * AW'(MAX_COLS) + AW'(item_r.col_index);

  // read address: scan row or segment corner
  logic [RB-1:0] rd_row;
  logic [1:0]    rd_col;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  always_comb begin
    rd_row = scan_row;
    rd_col = item_r.abscissa_col;
    if (cmd.rd_fetch) begin
      rd_row = (cmd.rd_sel == FETCH_X1 || cmd.rd_sel == FETCH_Y1) ? seg_r + RB'(1) : seg_r;
      rd_col = (cmd.rd_sel == FETCH_Y0 || cmd.rd_sel == FETCH_Y1) ?
               item_r.ordinate_col : item_r.abscissa_col;
    end
  end
  assign rd_ok   = (32'(rd_col) < MAX_COLS);
  assign rd_addr = rd_ok ? AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col) : '0;

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= item_r.value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= rd_ok;
    end
  end
  assign rd_word = rd_ok_r ? $signed(rd_data_r) : '0;

  // scan: order check and first row with x <= abscissa
  logic found_eff;
  logic hit;
  assign found_eff = cmd.scan_first ? 1'b0 : found_r;
  assign hit       = cmd.scan_inner && !found_eff && (item_r.query_x <= rd_word);
  always_ff @(posedge clk) begin
    if (cmd.scan_proc) begin
      prev_r <= rd_word;
      if (cmd.scan_first) begin
        order_r <= 1'b0;
      end else if (rd_word < prev_r) begin
        order_r <= 1'b1;
      end
      found_r <= found_eff || hit;
      if (hit) begin
        k_r <= proc_row;
      end
      if (cmd.scan_last) begin
        last_r <= rd_word;
      end
    end
  end

  // segment choice
  logic [NW-1:0] n_m2;
  logic [RB-1:0] k_m1;
  assign n_m2 = num_rows - NW'(2);
  assign k_m1 = k_r - RB'(1);
  always_ff @(posedge clk) begin
    if (cmd.seg_calc) begin
      if (item_r.query_x > last_r || !found_r) begin
        seg_r <= n_m2[RB-1:0];
      end else begin
        seg_r <= (k_r == '0) ? '0 : k_m1;
      end
    end
  end

  // corner capture
  always_ff @(posedge clk) begin
    if (cmd.fetch_cap) begin
      case (cmd.cap_sel)
        FETCH_X0: x0_r <= rd_word;
        FETCH_X1: x1_r <= rd_word;
        FETCH_Y0: y0_r <= rd_word;
        FETCH_Y1: y1_r <= rd_word;
        default:  x0_r <= rd_word;
      endcase
    end
  end

  // differences, magnitudes and product
  logic signed [32:0] dx_neg, dy_neg, t_neg;
  logic [MAG_W-1:0]   dx_mag, dy_mag, t_mag;
  assign dx_neg = -dx_r;
  assign dy_neg = -dy_r;
  assign t_neg  = -t_r;
  assign dx_mag = dx_r[32] ? dx_neg[31:0] : dx_r[31:0];
  assign dy_mag = dy_r[32] ? dy_neg[31:0] : dy_r[31:0];
  assign t_mag  = t_r[32]  ? t_neg[31:0]  : t_r[31:0];
  assign sts.dx_zero = (dx_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= 33'(x1_r) - 33'(x0_r);
      dy_r <= 33'(y1_r) - 33'(y0_r);
      t_r  <= 33'(item_r.query_x) - 33'(x0_r);
    end
    if (cmd.mul) begin
      p_r   <= 64'(t_mag) * 64'(dy_mag);
      d_r   <= dx_mag;
      neg_r <= t_r[32] ^ dy_r[32] ^ dx_r[32];
    end
  end

  // restoring divide, one quotient bit a cycle
  logic [MAG_W:0] trial, trial_sub;
  logic           ge;
  assign trial     = {rem_r, num_r[NUM_W-1]};
  assign ge        = trial >= {1'b0, d_r};
  assign trial_sub = trial - {1'b0, d_r};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= NUM_W'(p_r) + NUM_W'(d_r[MAG_W-1:1]);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  // signed add and saturation
  logic               big;
  logic signed [36:0] qv, term, sum;
  assign big  = (|num_r[NUM_W-1:35]) || (num_r[34] && (|num_r[33:0]));
  assign qv   = {2'b00, num_r[34:0]};
  assign term = neg_r ? -qv : qv;
  assign sum  = 37'(y0_r) + term;

  always_ff @(posedge clk) begin
    if (cmd.load_done) begin
      res_r <= '0;
    end else if (cmd.dz_done) begin
      res_r.result      <= '0;
      res_r.order_error <= order_r;
      res_r.div_zero    <= 1'b1;
    end else if (cmd.sum) begin
      res_r.order_error <= order_r;
      res_r.div_zero    <= 1'b0;
      if (big) begin
        res_r.result <= (neg_r && p_r != '0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (sum > SAT_MAX) begin
        res_r.result <= 32'sh7fff_ffff;
      end else if (sum < SAT_MIN) begin
        res_r.result <= 32'sh8000_0000;
      end else begin
        res_r.result <= sum[31:0];
      end
    end
  end
  assign res = res_r;

endmodule
`default_nettype wire

### sim/table_linear_interpolator_core_test.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_core_test
// Self-checking bench for the table interpolator: loads tables through the
// input channel, runs queries under several idle and stall mixes and checks
// every result word against a behavioral interpolator kept in the bench.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tli_pkg::*;

  localparam int ROWS = 256;
  localparam int COLS = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_ITEMS = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tli_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tli_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [8:0] cfg_wr_data = '0;

  // predictor state
  logic [31:0] table_mirror [ROWS*COLS];
  int unsigned rows_in_use = 2;

  tli_out_t expected_words [$];
  int errors = 0;
  int watchdog = 0;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  table_linear_interpolator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint entry(int unsigned r, int unsigned c);
    return longint'($signed(table_mirror[r*COLS + c]));
  endfunction

  // behavioral interpolator: returns the result word for one input word
  function automatic tli_out_t interpolate(tli_in_t w);
    tli_out_t o;
    int unsigned n, seg, k;
    longint x, x0, x1, y0, y1, dx, dy, t, sum;
    longint unsigned p, d, q;
    bit neg;
    o = '0;
    if (w.cmd == CMD_LOAD) begin
      table_mirror[w.row_index*COLS + w.col_index] = w.value;
      return o;
    end
    n = rows_in_use < 2 ? 2 : (rows_in_use > ROWS ? ROWS : rows_in_use);
    x = longint'(w.query_x);
    for (int i = 0; i + 1 < n; i++)
      if (entry(i+1, w.abscissa_col) < entry(i, w.abscissa_col)) o.order_error = 1'b1;
    if (x > entry(n-1, w.abscissa_col)) seg = n - 2;
    else if (x < entry(0, w.abscissa_col)) seg = 0;
    else begin
      k = 0;
      while (k < n - 1 && x > entry(k, w.abscissa_col)) k++;
      seg = (k == 0) ? 0 : k - 1;
    end
    x0 = entry(seg, w.abscissa_col);
    x1 = entry(seg+1, w.abscissa_col);
    y0 = entry(seg, w.ordinate_col);
    y1 = entry(seg+1, w.ordinate_col);
    dx = x1 - x0;
    dy = y1 - y0;
    t = x - x0;
    if (dx == 0) begin
      o.div_zero = 1'b1;
      return o;
    end
    d = dx < 0 ? -dx : dx;
    p = longint'(t < 0 ? -t : t) * longint'(dy < 0 ? -dy : dy);
    q = (p + d/2) / d;
    neg = ((t < 0) != (dy < 0)) != (dx < 0);
    if (q > (64'd1 << 34)) sum = (neg && p != 0) ? -(64'sd1 <<< 40) : (64'sd1 <<< 40);
    else sum = y0 + (neg ? -longint'(q) : longint'(q));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    o.result = sum[31:0];
    return o;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk) begin
    tli_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data.result, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.result !== want.result)
            report_mismatch("result", out_data.result, want.result);
          if (out_data.order_error !== want.order_error)
            report_mismatch("order_error", out_data.order_error, want.order_error);
          if (out_data.div_zero !== want.div_zero)
            report_mismatch("div_zero", out_data.div_zero, want.div_zero);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("table_linear_interpolator_core regression: fail");
      $finish;
    end
  end

  // drive one word and wait for its acceptance; valid stays up for the next
  task automatic send_word(input tli_in_t w, input bit has_want, input tli_out_t want);
    tli_out_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = interpolate(w);
    if (has_want && pred !== want) report_mismatch("table row predictor", pred, want);
    expected_words.push_back(has_want ? want : pred);
    sent++;
  endtask

  function automatic tli_in_t load_word(int r, int c, logic [31:0] v);
    tli_in_t w;
    w = tli_in_t'(($bits(tli_in_t))'({$urandom, $urandom, $urandom}));
    w.cmd = CMD_LOAD;
    w.row_index = 8'(r);
    w.col_index = 2'(c);
    w.value = v;
    return w;
  endfunction

  function automatic tli_in_t query_word(logic [31:0] x, int ac, int oc);
    tli_in_t w;
    w = tli_in_t'(($bits(tli_in_t))'({$urandom, $urandom, $urandom}));
    w.cmd = CMD_QUERY;
    w.query_x = x;
    w.abscissa_col = 2'(ac);
    w.ordinate_col = 2'(oc);
    return w;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (rows_in_use + 100) @(posedge clk);
  endtask

  task automatic set_rows(input int unsigned v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[8:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rows_in_use = v[8:0];
  endtask

  // fill the rows in use over the first ncols columns; abscissa col ac sorted
  // or random, others random
  task automatic fill_table(input int unsigned n, input bit sorted, input int ac,
                            input int ncols);
    logic [31:0] xv;
    int step;
    xv = -$urandom_range(1 << 20);
    step = (n > 40) ? 2000 : 200000;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < ncols; c++) begin
        if (c == ac && sorted) begin
          send_word(load_word(r, c, xv), 0, '0);
          xv += ($urandom_range(3) == 0) ? 0 : $urandom_range(step);
        end else begin
          send_word(load_word(r, c, ($urandom_range(3) == 0) ? {$urandom} :
                    $signed($urandom_range(1 << 22)) - (1 << 21)), 0, '0);
        end
      end
  endtask

  typedef struct {
    tli_in_t w;
    bit typed;
    tli_out_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows [$];
    int n, ac;
    tli_out_t z;
    z = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-row table, extremes and special cases
    rows.push_back('{load_word(0, 0, 32'sd0), 1, z});
    rows.push_back('{load_word(1, 0, 32'sd65536), 1, z});
    rows.push_back('{load_word(0, 1, 32'sd0), 1, z});
    rows.push_back('{load_word(1, 1, 32'sd131072), 1, z});
    rows.push_back('{load_word(0, 2, 32'h80000000), 1, z});
    rows.push_back('{load_word(1, 2, 32'h7fffffff), 1, z});
    rows.push_back('{load_word(0, 3, 32'sd5), 1, z});
    rows.push_back('{load_word(1, 3, 32'sd5), 1, z});
    rows.push_back('{load_word(255, 3, 32'hffffffff), 1, z});
    rows.push_back('{query_word(32'sd0, 0, 1), 1, z});
    rows.push_back('{query_word(32'sd65536, 0, 1), 1, '{32'sd131072, 1'b0, 1'b0}});
    rows.push_back('{query_word(32'sd32768, 0, 1), 1, '{32'sd65536, 1'b0, 1'b0}});
    rows.push_back('{query_word(32'h7fffffff, 0, 1), 1, '{32'h7fffffff, 1'b0, 1'b0}});
    rows.push_back('{query_word(32'h80000000, 0, 1), 1, '{32'h80000000, 1'b0, 1'b0}});
    rows.push_back('{query_word(32'sd12345, 3, 0), 1, '{32'sd0, 1'b0, 1'b1}});
    rows.push_back('{query_word(32'sd100, 2, 0), 0, z});
    rows.push_back('{query_word(32'h80000000, 2, 1), 0, z});
    rows.push_back('{query_word(32'sd77777, 1, 2), 0, z});
    rows.push_back('{query_word(32'sd3, 0, 2), 0, z});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

    // decreasing abscissa with three rows
    set_rows(3);
    send_word(load_word(2, 0, 32'sd1000), 0, z);
    send_word(load_word(2, 1, 32'sd7), 0, z);
    send_word(query_word(32'sd500, 0, 1), 0, z);
    send_word(query_word(32'sd65536, 0, 1), 0, z);

    // saturation of the register below two and above table size
    set_rows(0);
    send_word(query_word(32'sd40000, 0, 1), 0, z);
    set_rows(1);
    send_word(query_word(32'sd40000, 0, 1), 0, z);
    set_rows(256);
    fill_table(256, 1, 0, 2);
    send_word(query_word($urandom, 0, 1), 0, z);
    set_rows(511);
    send_word(query_word($urandom, 0, 1), 0, z);
    set_rows(300);
    send_word(query_word($urandom, 0, 1), 0, z);

    // random: phases over table sizes and idle mixes
    for (int ph = 0; sent < N_ITEMS || ph < 4; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(8, 2);
      ac = $urandom_range(3);
      set_rows(n);
      fill_table(n, $urandom_range(5) != 0, ac, COLS);
      repeat (60) begin
        logic [31:0] x;
        int r;
        r = $urandom_range(n - 1);
        case ($urandom_range(3))
          0: x = $urandom;
          1: x = table_mirror[r*COLS + ac];
          default: x = table_mirror[r*COLS + ac] + $signed($urandom_range(4000)) - 2000;
        endcase
        if ($urandom_range(15) == 0)
          send_word(load_word($urandom_range(n - 1), $urandom_range(3), $urandom), 0, z);
        else
          send_word(query_word(x, ac, ($urandom_range(3) == 0) ? ac : $urandom_range(3)),
                    0, z);
      end
      // hold the sender until every result is back
      if (ph == 2) drain();
    end

    drain();
    if (errors == 0) $display("table_linear_interpolator_core regression: pass");
    else $display("table_linear_interpolator_core regression: fail");
    $finish;
  end
endmodule
